FILE: hw/rtl/csh_pkg.sv
// shared types, widths and reset constants for the command string hash matcher
`default_nettype none
package csh_pkg;

  // field widths
  localparam int CHAR_W = 8;
  localparam int LEN_W  = 8;
  localparam int HASH_W = 16;
  localparam int CNT_W  = 6;

  // table sizing: entries actually compared is the smaller of the two
  localparam int NUM_REGS      = 5;
  localparam int TABLE_ENTRIES = 5;
  localparam int CMP_ENTRIES   = (TABLE_ENTRIES < NUM_REGS) ? TABLE_ENTRIES : NUM_REGS;
  localparam int IDX_W         = 3;
  localparam int CFG_AW        = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  // stream packing
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  typedef logic [NUM_REGS-1:0][HASH_W-1:0] hash_tbl_t;

  // reset contents of the command hash table
  localparam hash_tbl_t RESET_HASHES = {
    16'hAD1A, 16'h5987, 16'h1106, 16'h116a, 16'h3eac
  };

  typedef struct packed {
    logic [CHAR_W-1:0] char_byte;
    logic [LEN_W-1:0]  string_length;
    logic              is_last;
  } item_t;

  typedef struct packed {
    logic [HASH_W-1:0] final_hash;
    logic [IDX_W-1:0]  match_index;
    logic              matched;
  } result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/csh_in_stage.sv
// input register stage holding one accepted character word
`default_nettype none
module csh_in_stage
  import csh_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  input  wire logic                 in_tlast,
  input  wire logic                 advance,
  output logic                      item_valid,
  output item_t                     item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  // free when empty or when the held word moves on this cycle
  assign in_tready = !valid_r || advance;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (load) begin
      item_r.char_byte     <= in_tdata[CHAR_W-1:0];
      item_r.string_length <= in_tdata[CHAR_W+LEN_W-1:CHAR_W];
      item_r.is_last       <= in_tlast;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule
`default_nettype wire

FILE: hw/rtl/csh_cfg_regs.sv
// command hash table registers with a plain write port
`default_nettype none
module csh_cfg_regs
  import csh_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [HASH_W-1:0] cfg_wdata,
  output hash_tbl_t              entry_hashes
);

  hash_tbl_t tbl_r;

  // writes beyond the table are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_r <= RESET_HASHES;
    end else if (cfg_we && (32'(cfg_addr) < NUM_REGS)) begin
      tbl_r[cfg_addr] <= cfg_wdata;
    end
  end

  assign entry_hashes = tbl_r;

endmodule
`default_nettype wire

FILE: hw/rtl/csh_hash_core.sv
// running hash, position and stride state with table lookup on the last character
`default_nettype none
module csh_hash_core
  import csh_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      fire,
  input  wire item_t     item,
  input  wire hash_tbl_t entry_hashes,
  output result_t        result
);

  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [LEN_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [HASH_W-1:0] fold_sum;
  logic [HASH_W-1:0] hash_new;
  logic [IDX_W-1:0]  idx;
  logic              hit;

  // shift-add-xor fold, modulo 2^16
  assign fold_sum = (hash_r << 5) + (hash_r >> 2) + HASH_W'(item.char_byte);

  // sample on countdown zero, only within the string length
  always_comb begin
    hash_new = hash_r;
    if (cnt_r == '0) begin
      if (pos_r < item.string_length) begin
        hash_new = hash_r ^ fold_sum;
      end
      cnt_nxt = {1'b0, item.string_length[LEN_W-1:3]};
    end else begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    pos_nxt  = (pos_r == '1) ? pos_r : pos_r + LEN_W'(1);
    hash_nxt = hash_new;
    if (item.is_last) begin
      hash_nxt = '0;
      pos_nxt  = '0;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= '0;
      pos_r  <= '0;
      cnt_r  <= '0;
    end else if (fire) begin
      hash_r <= hash_nxt;
      pos_r  <= pos_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // parallel compare, lowest matching entry wins
  always_comb begin
    idx = IDX_W'(CMP_ENTRIES);
    hit = 1'b0;
    for (int i = CMP_ENTRIES - 1; i >= 0; i--) begin
      if (entry_hashes[i] == hash_new) begin
        idx = IDX_W'(i);
        hit = 1'b1;
      end
    end
  end

  assign result.final_hash  = hash_new;
  assign result.match_index = idx;
  assign result.matched     = hit;

endmodule
`default_nettype wire

FILE: hw/rtl/command_string_hash_matcher_top.sv
// top level of the command string hash matcher
//
//  port group  dir  contents
//  in_*        in   tdata[7:0] char_byte, tdata[15:8] string_length, tlast is_last
//  out_*       out  tdata[15:0] final_hash, tdata[18:16] match_index, tuser matched
//  cfg_*       in   write of entry_hash_0..4 at index 0..4, others ignored
//
// one character word per cycle sustained unless a stalled result holds a last word; the hash fold
// and the five compares sit between the input register and the result register.
// synchronous active-low reset restores the table and clears the hash state.
// a stalled result holds back the last word of the next string, and the input behind it.
`default_nettype none
module command_string_hash_matcher_top
  import csh_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // char_byte, string_length
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // final_hash, match_index, zero pad
  output logic                       out_tuser,  // matched
  input  wire logic                  cfg_we,
  input  wire logic [CFG_AW-1:0]     cfg_addr,
  input  wire logic [HASH_W-1:0]     cfg_wdata
);

  logic      s1_valid;
  item_t     s1_item;
  logic      advance;
  hash_tbl_t entry_hashes;
  result_t   core_res;
  logic      out_valid_r, out_valid_nxt;
  result_t   out_res_r;

  csh_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .advance    (advance),
    .item_valid (s1_valid),
    .item       (s1_item)
  );

  csh_cfg_regs u_cfg_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .entry_hashes (entry_hashes)
  );

  // a last word needs room in the result register
  assign advance = s1_valid && (!s1_item.is_last || !out_valid_r || out_tready);

  csh_hash_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (advance),
    .item         (s1_item),
    .entry_hashes (entry_hashes),
    .result       (core_res)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && s1_item.is_last) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_item.is_last) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - HASH_W - IDX_W)'(0), out_res_r.match_index,
                       out_res_r.final_hash};
  assign out_tuser  = out_res_r.matched;

endmodule
`default_nettype wire

FILE: dv/csh_lookup_checker.sv
// scoreboard for the command string hash matcher: predicts every lookup and checks result words
`timescale 1ns / 100ps
module csh_lookup_checker
  import csh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // char_byte, string_length
  input  logic                  in_tlast,   // is_last
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // final_hash, match_index, zero pad
  input  logic                  out_tuser,  // matched
  input  logic                  cfg_we,
  input  logic [CFG_AW-1:0]     cfg_addr,
  input  logic [HASH_W-1:0]     cfg_wdata,
  output int                    fail_count,
  output int                    lookups_pending,
  output int                    lookups_checked,
  output int                    hits_seen,
  output logic [HASH_W-1:0]     last_string_hash
);

  // own copy of the hash state and the command table
  logic [HASH_W-1:0] acc_hash;
  logic [LEN_W-1:0]  char_pos;
  logic [CNT_W-1:0]  skip_left;
  hash_tbl_t         entry_tbl;
  result_t           lookup_q[$];

  initial begin
    fail_count       = 0;
    lookups_pending  = 0;
    lookups_checked  = 0;
    hits_seen        = 0;
    last_string_hash = '0;
  end

  // shift-add-xor fold of one character, modulo 2^16
  function automatic logic [HASH_W-1:0] fold_char(input logic [HASH_W-1:0] h,
                                                  input logic [CHAR_W-1:0] ch);
    logic [HASH_W-1:0] mix;
    mix = (h << 5) + (h >> 2) + HASH_W'(ch);
    return h ^ mix;
  endfunction

  // lowest matching entry wins; no match gives the number of compared entries
  function automatic result_t look_up(input hash_tbl_t tbl, input logic [HASH_W-1:0] h);
    result_t r;
    r.final_hash  = h;
    r.match_index = IDX_W'(CMP_ENTRIES);
    r.matched     = 1'b0;
    for (int i = CMP_ENTRIES - 1; i >= 0; i--) begin
      if (tbl[i] == h) begin
        r.match_index = IDX_W'(i);
        r.matched     = 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    logic [CHAR_W-1:0] ch;
    logic [LEN_W-1:0]  len;
    result_t           got;
    result_t           want;
    if (!rst_n) begin
      acc_hash  = '0;
      char_pos  = '0;
      skip_left = '0;
      entry_tbl = RESET_HASHES;
      lookup_q.delete();
    end else begin
      // table writes; indexes past the table are dropped
      if (cfg_we && cfg_addr < NUM_REGS) entry_tbl[cfg_addr] = cfg_wdata;

      // input word: fold when the countdown is spent and the position is inside the length
      if (in_tvalid && in_tready) begin
        ch  = in_tdata[CHAR_W-1:0];
        len = in_tdata[CHAR_W +: LEN_W];
        if (skip_left == '0) begin
          if (char_pos < len) acc_hash = fold_char(acc_hash, ch);
          skip_left = CNT_W'(len >> 3);
        end else begin
          skip_left = skip_left - 1'b1;
        end
        if (char_pos != '1) char_pos = char_pos + 1'b1;
        if (in_tlast) begin
          lookup_q.push_back(look_up(entry_tbl, acc_hash));
          last_string_hash <= acc_hash;
          acc_hash  = '0;
          char_pos  = '0;
          skip_left = '0;
        end
      end

      // result word against the oldest expectation
      if (out_tvalid && out_tready) begin
        got.final_hash  = out_tdata[HASH_W-1:0];
        got.match_index = out_tdata[HASH_W +: IDX_W];
        got.matched     = out_tuser;
        if (lookup_q.size() == 0) begin
          $display("%0t: unexpected result word hash %h index %0d matched %b",
                   $time, got.final_hash, got.match_index, got.matched);
          fail_count <= fail_count + 1;
        end else begin
          want = lookup_q.pop_front();
          lookups_checked <= lookups_checked + 1;
          if (want.matched) hits_seen <= hits_seen + 1;
          if (got !== want || out_tdata[OUT_DATA_W-1:HASH_W+IDX_W] !== '0) begin
            $display("%0t: mismatch expected hash %h index %0d matched %b pad 0, got %h %0d %b pad %h",
                     $time, want.final_hash, want.match_index, want.matched,
                     got.final_hash, got.match_index, got.matched,
                     out_tdata[OUT_DATA_W-1:HASH_W+IDX_W]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    lookups_pending <= lookup_q.size();
  end

endmodule

FILE: dv/tb_command_string_hash_matcher_top.sv
// testbench top for the command string hash matcher: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module tb_command_string_hash_matcher_top;
  import csh_pkg::*;

  localparam int TOTAL_ITEMS  = 1900;
  localparam int PHASE_ITEMS  = 190;
  localparam int IDLE_PCT     = 21;
  localparam int DRAIN_CYCLES = 6;
  localparam int MAX_TEXT     = 320;
  // idle runs are short and a table reload stalls the streams only while it settles and writes
  localparam int STALL_LIMIT  = 2000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // char_byte, string_length
  logic                  in_tlast   = 1'b0;  // is_last
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // final_hash, match_index, zero pad
  logic                  out_tuser;        // matched
  logic                  cfg_we     = 1'b0;
  logic [CFG_AW-1:0]     cfg_addr   = '0;
  logic [HASH_W-1:0]     cfg_wdata  = '0;

  int                    fail_count;
  int                    lookups_pending;
  int                    lookups_checked;
  int                    hits_seen;
  logic [HASH_W-1:0]     last_string_hash;

  // no idling on either side while set
  logic                  steady = 1'b0;
  int                    items_sent  = 0;
  int                    strings_sent = 0;
  int                    table_writes = 0;

  // string being sent, and remembered strings whose hashes go into the table
  logic [CHAR_W-1:0]     text_chr [MAX_TEXT];
  logic [LEN_W-1:0]      text_len [MAX_TEXT];
  int                    text_n;
  logic [CHAR_W-1:0]     slot_chr [NUM_REGS][MAX_TEXT];
  logic [LEN_W-1:0]      slot_len [NUM_REGS][MAX_TEXT];
  int                    slot_n   [NUM_REGS];
  logic [HASH_W-1:0]     slot_hash[NUM_REGS];

  command_string_hash_matcher_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  csh_lookup_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tlast         (in_tlast),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .lookups_pending  (lookups_pending),
    .lookups_checked  (lookups_checked),
    .hits_seen        (hits_seen),
    .last_string_hash (last_string_hash)
  );

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic idle_draw();
    return !steady && ($urandom_range(99) < IDLE_PCT);
  endfunction

  function automatic logic [CHAR_W-1:0] rand_char();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return CHAR_W'($urandom_range(255));
    endcase
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    out_tready <= !idle_draw();
  end

  // watchdog: too long without any word moving on either side
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stuck = 0;
      else stuck++;
    end
    $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // one character word, random idle cycles in front of it
  task automatic send_word(input logic [CHAR_W-1:0] ch, input logic [LEN_W-1:0] len,
                           input logic last);
    while (idle_draw()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {len, ch};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (last) strings_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_n; i++) send_word(text_chr[i], text_len[i], i == text_n - 1);
  endtask

  task automatic make_text(input int len, input int n);
    for (int i = 0; i < n; i++) begin
      text_chr[i] = rand_char();
      text_len[i] = LEN_W'(len);
    end
    text_n = n;
  endtask

  // stop sending and let every outstanding lookup come back
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (lookups_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_entry(input int idx, input logic [HASH_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_AW'(idx);
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    table_writes++;
  endtask

  // send a short well-formed string and remember it with its hash
  task automatic capture_slot(input int s);
    make_text($urandom_range(1, 24), 0);
    make_text(text_len[0] == 0 ? 1 : 0, 0);
    begin
      int len;
      len = $urandom_range(1, 24);
      make_text(len, len);
    end
    send_text();
    settle();
    slot_hash[s] = last_string_hash;
    slot_n[s]    = text_n;
    for (int i = 0; i < text_n; i++) begin
      slot_chr[s][i] = text_chr[i];
      slot_len[s][i] = text_len[i];
    end
  endtask

  task automatic replay_slot(input int s);
    for (int i = 0; i < slot_n[s]; i++) begin
      text_chr[i] = slot_chr[s][i];
      text_len[i] = slot_len[s][i];
    end
    text_n = slot_n[s];
    send_text();
  endtask

  // new table contents: extremes, random, duplicates and remembered hashes, sometimes a write past the table
  task automatic reload_table();
    logic [HASH_W-1:0] val;
    logic [HASH_W-1:0] prev;
    settle();
    prev = '0;
    for (int i = 0; i < NUM_REGS; i++) begin
      case ($urandom_range(5))
        0:       val = '0;
        1:       val = '1;
        2:       val = HASH_W'($urandom_range(65535));
        3:       val = prev;
        default: val = slot_hash[i];
      endcase
      write_entry(i, val);
      prev = val;
    end
    if ($urandom_range(99) < 30)
      write_entry($urandom_range(NUM_REGS, (1 << CFG_AW) - 1), HASH_W'($urandom_range(65535)));
  endtask

  task automatic send_random_string();
    int pick;
    int len;
    int n;
    pick = $urandom_range(99);
    if (pick < 30) begin
      replay_slot($urandom_range(NUM_REGS - 1));
    end else begin
      if (pick < 38) begin
        // empty string
        make_text(0, 1);
      end else if (pick < 50) begin
        // characters past the stated length
        len = $urandom_range(0, 12);
        make_text(len, len + $urandom_range(1, 8));
      end else if (pick < 58) begin
        // string cut short before its length
        len = $urandom_range(2, 255);
        make_text(len, $urandom_range(1, (len - 1 < 40) ? len - 1 : 40));
      end else if (pick < 66) begin
        // length moving from word to word
        n = $urandom_range(2, 30);
        make_text($urandom_range(255), n);
        for (int i = 0; i < n; i++)
          if ($urandom_range(2) == 0) text_len[i] = LEN_W'($urandom_range(255));
      end else if (pick < 67 && TOTAL_ITEMS - items_sent > 600) begin
        // past the saturation of the position counter
        make_text(255, $urandom_range(256, 290));
      end else begin
        len = ($urandom_range(99) < 85) ? $urandom_range(1, 40) : $urandom_range(41, 255);
        make_text(len, len);
      end
      send_text();
    end
  endtask

  initial begin : stimulus
    int phase;
    int phase_end;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty string against the reset table
    send_word(8'h5a, 8'd0, 1'b1);
    // single characters at both extremes
    send_word(8'hff, 8'd1, 1'b1);
    send_word(8'h00, 8'd1, 1'b1);
    // longest length: stride of 32, only the first word folds
    send_word(8'hff, 8'd255, 1'b0);
    send_word(8'h80, 8'd255, 1'b0);
    send_word(8'hff, 8'd255, 1'b1);
    // words past the length still count for position and stride
    for (int i = 0; i < 5; i++) send_word(CHAR_W'(8'h41 + i), 8'd2, i == 4);
    // length changing inside one string
    send_word(8'h31, 8'd9, 1'b0);
    send_word(8'h32, 8'd0, 1'b0);
    send_word(8'h33, 8'd200, 1'b0);
    send_word(8'h34, 8'd9, 1'b1);
    // stride of two
    for (int i = 0; i < 4; i++) send_word(CHAR_W'(8'h61 + i), 8'd8, i == 3);

    // all entries zero: the empty string hits the lowest index
    settle();
    for (int i = 0; i < NUM_REGS; i++) write_entry(i, '0);
    send_word(8'h00, 8'd0, 1'b1);
    // entry 0 at full scale, writes past the table dropped
    settle();
    write_entry(0, '1);
    for (int i = NUM_REGS; i < (1 << CFG_AW); i++) write_entry(i, '1);
    send_word(8'h7e, 8'd0, 1'b1);

    // remembered strings, loaded into the table and sent again
    for (int s = 0; s < NUM_REGS; s++) capture_slot(s);
    for (int s = 0; s < NUM_REGS; s++) write_entry(s, slot_hash[s]);
    for (int s = 0; s < NUM_REGS; s++) replay_slot(s);

    // random phases, each with a fresh table
    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      reload_table();
      steady = (phase == 3 || phase == 4);
      if (phase == 2) begin
        make_text(255, 270);
        send_text();
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) send_random_string();
      capture_slot($urandom_range(NUM_REGS - 1));
      phase++;
    end
    steady = 1'b0;

    settle();
    $display("sent %0d character words in %0d strings over %0d table settings, %0d table writes",
             items_sent, strings_sent, phase, table_writes);
    $display("checked %0d lookups, %0d of them hits", lookups_checked, hits_seen);
    if (fail_count == 0 && lookups_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
